// ----- rtl/ddpc_pkg.sv -----
package ddpc_pkg;

	localparam int Q_PI       = 205887;
	localparam int Q_TWO_PI   = 411775;
	localparam int Q_HALF_PI  = 102944;
	localparam int Q_CORDIC_K = 39797;
	localparam int Q_ONE      = 65536;

	localparam int CORDIC_STEPS_DEF = 16;

	localparam int HD_W     = 19;
	localparam int XY_W     = 36;
	localparam int Z_W      = 22;
	localparam int MA_W     = 36;
	localparam int MB_W     = 33;
	localparam int P_W      = MA_W + MB_W;
	localparam int WR_W     = 33;
	localparam int WRAP_TOP = 14;
	localparam int CFG_W    = 31;

	typedef enum logic [2:0] {
		REG_MAX_LIN   = 3'd0,
		REG_MAX_TURN  = 3'd1,
		REG_POS_TOL   = 3'd2,
		REG_HD_TOL    = 3'd3,
		REG_WHEEL_W   = 3'd4,
		REG_INV_TRACK = 3'd5,
		REG_HD_ONLY   = 3'd6
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_LOADW, S_DANG, S_V1, S_V2, S_W1, S_W2, S_DISP, S_DTH,
		S_MID, S_MIDW, S_ROT, S_PX, S_PY, S_HDW, S_DIFF, S_VEC, S_RHO,
		S_ALPHAW, S_BETAW, S_ERRW, S_T1, S_T2, S_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic rotate;
	} cordic_ctl_t;

	function automatic logic [16:0] atan_lut(input logic [4:0] i);
		case (i)
			5'd0:    return 17'd51472;
			5'd1:    return 17'd30386;
			5'd2:    return 17'd16055;
			5'd3:    return 17'd8150;
			5'd4:    return 17'd4091;
			5'd5:    return 17'd2047;
			5'd6:    return 17'd1024;
			5'd7:    return 17'd512;
			5'd8:    return 17'd256;
			5'd9:    return 17'd128;
			5'd10:   return 17'd64;
			5'd11:   return 17'd32;
			5'd12:   return 17'd16;
			5'd13:   return 17'd8;
			5'd14:   return 17'd4;
			5'd15:   return 17'd2;
			5'd16:   return 17'd1;
			default: return 17'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
		if (v > 54'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -54'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [31:0] clampsym(input logic signed [53:0] v,
			input logic [CFG_W-1:0] lim);
		logic signed [53:0] l;
		logic signed [53:0] nl;
		l  = $signed({23'd0, lim});
		nl = -l;
		if (v > l)
			return l[31:0];
		else if (v < nl)
			return nl[31:0];
		else
			return v[31:0];
	endfunction

endpackage

// ----- rtl/ddpc_if.sv -----
interface ddpc_step_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [16:0]        time_step;
	logic signed [31:0] left_wheel_speed;
	logic signed [31:0] right_wheel_speed;
	logic signed [31:0] imu_forward_speed;
	logic signed [31:0] imu_yaw_rate;
	logic signed [31:0] distance_gain;
	logic signed [31:0] bearing_gain;
	logic signed [31:0] final_heading_gain;
	logic signed [31:0] pose_x_value;
	logic signed [31:0] pose_y_value;
	logic signed [18:0] pose_heading_value;

	modport source(output valid, req_type, time_step, left_wheel_speed, right_wheel_speed,
		imu_forward_speed, imu_yaw_rate, distance_gain, bearing_gain, final_heading_gain,
		pose_x_value, pose_y_value, pose_heading_value, input ready);
	modport sink(input valid, req_type, time_step, left_wheel_speed, right_wheel_speed,
		imu_forward_speed, imu_yaw_rate, distance_gain, bearing_gain, final_heading_gain,
		pose_x_value, pose_y_value, pose_heading_value, output ready);
endinterface

interface ddpc_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] linear_command;
	logic signed [31:0] turn_command;
	logic signed [31:0] estimate_x;
	logic signed [31:0] estimate_y;
	logic signed [18:0] estimate_heading;
	logic               goal_reached;

	modport source(output valid, linear_command, turn_command, estimate_x, estimate_y,
		estimate_heading, goal_reached, input ready);
	modport sink(input valid, linear_command, turn_command, estimate_x, estimate_y,
		estimate_heading, goal_reached, output ready);
endinterface

// ----- rtl/diff_drive_pose_controller.sv -----
// Control step: five passes of the 2*pi reduction unit and two passes of the shared
// CORDIC. Pose load: one pass of the reduction unit. One beat in flight; the result
// waits in an output register, and no new beat is taken until the last has moved
// there. Reset (arst_n low, async) zeroes the pose, restores register defaults and
// empties the output.
module diff_drive_pose_controller
	import ddpc_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	ddpc_step_if.sink             step,
	ddpc_result_if.source         result
);

	state_t state_q, state_d;

	// registers
	logic [CFG_W-1:0] max_lin_q, max_turn_q, pos_tol_q, hd_tol_q, inv_q;
	logic [16:0]      wheel_q;
	logic             hd_only_q;

	// pose
	logic signed [31:0]     px_q, py_q;
	logic signed [HD_W-1:0] hd_q;

	// latched beat
	logic                   rt_q;
	logic [16:0]            dt_q;
	logic signed [31:0]     lw_q, rw_q, iv_q, iw_q, kd_q, kb_q, kh_q, gx_q, gy_q;
	logic signed [HD_W-1:0] gh_q;

	// working values
	logic signed [P_W-1:0]  acc_q;
	logic signed [31:0]     dang_q, v_q, om_q, disp_q, dth_q;
	logic                   rot_neg_q, zero_q;
	logic signed [32:0]     ddx_q, ddy_q;
	logic signed [Z_W-1:0]  lam_q;
	logic [CFG_W-1:0]       rho_q;
	logic signed [HD_W-1:0] alpha_q, beta_q;
	logic [HD_W-2:0]        eh_q;
	logic signed [52:0]     tacc_q;
	logic signed [31:0]     lin_q, turn_q;
	logic                   reached_q;

	// output register
	logic                   res_valid_q;
	logic signed [31:0]     o_lin_q, o_turn_q, o_x_q, o_y_q;
	logic signed [HD_W-1:0] o_hd_q;
	logic                   o_reached_q;

	// shared units
	logic                   mul_go;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [P_W-1:0]  prod;
	logic                   wrap_go, wrap_done;
	logic signed [WR_W-1:0] wrap_a;
	logic signed [HD_W-1:0] wrap_res;
	cordic_ctl_t            cctl;
	logic signed [XY_W-1:0] cx0, cy0, cx, cy;
	logic signed [Z_W-1:0]  cz0, cz;
	logic                   c_done;

	logic                   step_fire, out_free;
	logic [16:0]            w_eff, wc;
	logic signed [32:0]     lr_sum, rwl;
	logic signed [31:0]     dlin;
	logic signed [52:0]     psh;
	logic signed [53:0]     psh54;
	logic signed [P_W:0]    vsum;
	logic signed [31:0]     dth_now;
	logic signed [XY_W-1:0] cos_v, sin_v;
	logic signed [Z_W-1:0]  rot_z;
	logic                   rot_neg;
	logic signed [32:0]     ddx_now, ddy_now;
	logic signed [XY_W-1:0] vec_x, vec_y;
	logic signed [Z_W-1:0]  vec_z;
	logic [32:0]            ax, ay;
	logic                   xy_ok;

	assign step_fire = step.valid && step.ready;
	assign out_free  = !res_valid_q || result.ready;

	always_comb begin
		w_eff   = (wheel_q > 17'd65536) ? 17'd65536 : wheel_q;
		wc      = 17'(Q_ONE) - w_eff;
		lr_sum  = 33'(lw_q) + 33'(rw_q);
		dlin    = lr_sum[32:1];
		rwl     = 33'(rw_q) - 33'(lw_q);
		psh     = $signed(prod[P_W-1:16]);
		psh54   = 54'(psh);
		vsum    = (P_W + 1)'(acc_q) + (P_W + 1)'(prod);
		dth_now = sat32(psh54);
		cos_v   = rot_neg_q ? -cx : cx;
		sin_v   = rot_neg_q ? -cy : cy;
		ddx_now = 33'(gx_q) - 33'(px_q);
		ddy_now = 33'(gy_q) - 33'(py_q);
		ax      = ddx_q[32] ? 33'(-ddx_q) : 33'(ddx_q);
		ay      = ddy_q[32] ? 33'(-ddy_q) : 33'(ddy_q);
		xy_ok   = hd_only_q || (ax < {2'b0, pos_tol_q} && ay < {2'b0, pos_tol_q});
	end

	// fold the midpoint heading into the right half plane before rotation
	always_comb begin
		rot_neg = 1'b0;
		rot_z   = Z_W'(wrap_res);
		if (wrap_res > Q_HALF_PI) begin
			rot_z   = Z_W'(wrap_res) - Z_W'(Q_PI);
			rot_neg = 1'b1;
		end else if (wrap_res < -Q_HALF_PI) begin
			rot_z   = Z_W'(wrap_res) + Z_W'(Q_PI);
			rot_neg = 1'b1;
		end
	end

	// goal in left half plane: mirror and start from +-pi
	always_comb begin
		vec_x = XY_W'(ddx_now);
		vec_y = XY_W'(ddy_now);
		vec_z = '0;
		if (ddx_now < 0) begin
			vec_x = -XY_W'(ddx_now);
			vec_y = -XY_W'(ddy_now);
			vec_z = (ddy_now >= 0) ? Z_W'(Q_PI) : Z_W'(-Q_PI);
		end
	end

	ddpc_mul u_mul (
		.clk  (clk),
		.go   (mul_go),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ddpc_wrap u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wrap_go),
		.a      (wrap_a),
		.done   (wrap_done),
		.res    (wrap_res)
	);

	ddpc_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x0     (cx0),
		.y0     (cy0),
		.z0     (cz0),
		.done   (c_done),
		.x      (cx),
		.y      (cy),
		.z      (cz)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (step_fire) state_d = step.req_type ? S_LOAD : S_DANG;
			S_LOAD:   state_d = S_LOADW;
			S_LOADW:  if (wrap_done) state_d = S_FIN;
			S_DANG:   state_d = S_V1;
			S_V1:     state_d = S_V2;
			S_V2:     state_d = S_W1;
			S_W1:     state_d = S_W2;
			S_W2:     state_d = S_DISP;
			S_DISP:   state_d = S_DTH;
			S_DTH:    state_d = S_MID;
			S_MID:    state_d = S_MIDW;
			S_MIDW:   if (wrap_done) state_d = S_ROT;
			S_ROT:    if (c_done) state_d = S_PX;
			S_PX:     state_d = S_PY;
			S_PY:     state_d = S_HDW;
			S_HDW:    if (wrap_done) state_d = S_DIFF;
			S_DIFF:   state_d = S_VEC;
			S_VEC:    if (c_done) state_d = S_RHO;
			S_RHO:    state_d = S_ALPHAW;
			S_ALPHAW: if (wrap_done) state_d = S_BETAW;
			S_BETAW:  if (wrap_done) state_d = S_ERRW;
			S_ERRW:   if (wrap_done) state_d = S_T1;
			S_T1:     state_d = S_T2;
			S_T2:     state_d = S_FIN;
			S_FIN:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// unit controls and operand selection
	always_comb begin
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		wrap_go = 1'b0;
		wrap_a  = '0;
		cctl    = '0;
		cx0     = '0;
		cy0     = '0;
		cz0     = '0;
		unique case (state_q)
			S_LOAD: begin
				wrap_go = 1'b1;
				wrap_a  = WR_W'(gh_q);
			end
			S_DANG: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(rwl);
				mul_b  = $signed({2'b0, inv_q});
			end
			S_V1: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(dlin);
				mul_b  = $signed({16'd0, w_eff});
			end
			S_V2: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(iv_q);
				mul_b  = $signed({16'd0, wc});
			end
			S_W1: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(dang_q);
				mul_b  = $signed({16'd0, w_eff});
			end
			S_W2: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(iw_q);
				mul_b  = $signed({16'd0, wc});
			end
			S_DISP: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(v_q);
				mul_b  = $signed({16'd0, dt_q});
			end
			S_DTH: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(om_q);
				mul_b  = $signed({16'd0, dt_q});
			end
			S_MID: begin
				wrap_go = 1'b1;
				wrap_a  = WR_W'(hd_q) + WR_W'(dth_now >>> 1);
			end
			S_MIDW: begin
				if (wrap_done) begin
					cctl.start  = 1'b1;
					cctl.rotate = 1'b1;
					cx0         = XY_W'(Q_CORDIC_K);
					cz0         = rot_z;
				end
			end
			S_ROT: begin
				if (c_done) begin
					mul_go = 1'b1;
					mul_a  = MA_W'(disp_q);
					mul_b  = MB_W'(cos_v);
				end
			end
			S_PX: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(disp_q);
				mul_b  = MB_W'(sin_v);
			end
			S_PY: begin
				wrap_go = 1'b1;
				wrap_a  = WR_W'(hd_q) + WR_W'(dth_q);
			end
			S_DIFF: begin
				cctl.start = 1'b1;
				cx0        = vec_x;
				cy0        = vec_y;
				cz0        = vec_z;
			end
			S_VEC: begin
				if (c_done) begin
					mul_go = 1'b1;
					mul_a  = cx;
					mul_b  = MB_W'(Q_CORDIC_K);
				end
			end
			S_RHO: begin
				wrap_go = 1'b1;
				wrap_a  = WR_W'(lam_q) - WR_W'(hd_q);
			end
			S_ALPHAW: begin
				if (wrap_done) begin
					wrap_go = 1'b1;
					wrap_a  = WR_W'(gh_q) - WR_W'(lam_q);
				end
			end
			S_BETAW: begin
				if (wrap_done) begin
					wrap_go = 1'b1;
					wrap_a  = WR_W'(gh_q) - WR_W'(hd_q);
					mul_go  = 1'b1;
					mul_a   = MA_W'(kd_q);
					mul_b   = $signed({2'b0, rho_q});
				end
			end
			S_ERRW: begin
				if (wrap_done) begin
					mul_go = 1'b1;
					mul_a  = MA_W'(kb_q);
					mul_b  = MB_W'(alpha_q);
				end
			end
			S_T1: begin
				mul_go = 1'b1;
				mul_a  = MA_W'(kh_q);
				mul_b  = MB_W'(beta_q);
			end
			default: begin
			end
		endcase
	end

	// control, registers and pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			max_lin_q   <= 31'd65536;
			max_turn_q  <= 31'd65536;
			pos_tol_q   <= 31'd3277;
			hd_tol_q    <= 31'd3277;
			wheel_q     <= 17'd32768;
			inv_q       <= 31'd65536;
			hd_only_q   <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			hd_q        <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_LIN:   max_lin_q  <= cfg_data;
					REG_MAX_TURN:  max_turn_q <= cfg_data;
					REG_POS_TOL:   pos_tol_q  <= cfg_data;
					REG_HD_TOL:    hd_tol_q   <= cfg_data;
					REG_WHEEL_W:   wheel_q    <= cfg_data[16:0];
					REG_INV_TRACK: inv_q      <= cfg_data;
					REG_HD_ONLY:   hd_only_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_LOADW: begin
					if (wrap_done) begin
						px_q <= gx_q;
						py_q <= gy_q;
						hd_q <= wrap_res;
					end
				end
				S_PX:    px_q <= sat32(54'(px_q) + psh54);
				S_PY:    py_q <= sat32(54'(py_q) + psh54);
				S_HDW:   if (wrap_done) hd_q <= wrap_res;
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (step_fire) begin
					rt_q <= step.req_type;
					dt_q <= step.time_step;
					lw_q <= step.left_wheel_speed;
					rw_q <= step.right_wheel_speed;
					iv_q <= step.imu_forward_speed;
					iw_q <= step.imu_yaw_rate;
					kd_q <= step.distance_gain;
					kb_q <= step.bearing_gain;
					kh_q <= step.final_heading_gain;
					gx_q <= step.pose_x_value;
					gy_q <= step.pose_y_value;
					gh_q <= step.pose_heading_value;
				end
			end
			S_LOADW: begin
				if (wrap_done) begin
					lin_q     <= '0;
					turn_q    <= '0;
					reached_q <= 1'b0;
				end
			end
			S_V1:   dang_q <= sat32(psh54);
			S_V2:   acc_q  <= prod;
			S_W1:   v_q    <= vsum[47:16];
			S_W2:   acc_q  <= prod;
			S_DISP: om_q   <= vsum[47:16];
			S_DTH:  disp_q <= sat32(psh54);
			S_MID:  dth_q  <= dth_now;
			S_MIDW: if (wrap_done) rot_neg_q <= rot_neg;
			S_DIFF: begin
				ddx_q  <= ddx_now;
				ddy_q  <= ddy_now;
				zero_q <= ddx_now == 33'sd0 && ddy_now == 33'sd0;
			end
			S_VEC: if (c_done) lam_q <= zero_q ? '0 : cz;
			S_RHO: begin
				// x gain product is never negative after a vectoring pass from x >= 0
				if (psh < 0)
					rho_q <= '0;
				else if (psh > 53'sd2147483647)
					rho_q <= '1;
				else
					rho_q <= psh[CFG_W-1:0];
			end
			S_ALPHAW: if (wrap_done) alpha_q <= wrap_res;
			S_BETAW:  if (wrap_done) beta_q <= wrap_res;
			S_ERRW: begin
				if (wrap_done) begin
					eh_q  <= wrap_res[HD_W-1] ? (HD_W - 1)'(-wrap_res) : (HD_W - 1)'(wrap_res);
					lin_q <= hd_only_q ? 32'sd0 : clampsym(psh54, max_lin_q);
				end
			end
			S_T1: tacc_q <= psh;
			S_T2: begin
				turn_q    <= clampsym(54'(tacc_q) + psh54, max_turn_q);
				reached_q <= xy_ok && {13'd0, eh_q} < hd_tol_q;
			end
			S_FIN: begin
				if (out_free) begin
					o_lin_q     <= lin_q;
					o_turn_q    <= turn_q;
					o_x_q       <= px_q;
					o_y_q       <= py_q;
					o_hd_q      <= hd_q;
					o_reached_q <= reached_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign step.ready              = state_q == S_IDLE;
	assign result.valid            = res_valid_q;
	assign result.linear_command   = o_lin_q;
	assign result.turn_command     = o_turn_q;
	assign result.estimate_x       = o_x_q;
	assign result.estimate_y       = o_y_q;
	assign result.estimate_heading = o_hd_q;
	assign result.goal_reached     = o_reached_q;

	// the branch out of idle follows step.req_type directly; the latched request kind is not used by the datapath
	logic unused_rt;
	assign unused_rt = rt_q;

`ifndef SYNTHESIS
	a_heading_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		hd_q <= Q_PI && hd_q >= -Q_PI)
		else $error("stored heading left [-pi, pi]");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		step_fire |=> state_q != S_IDLE)
		else $error("sequencer idle right after accepting a beat");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside the finish step");

	a_load_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> rt_q)
		else $error("pose load entered for a control beat");
`endif

endmodule

// ----- rtl/ddpc_mul.sv -----
module ddpc_mul
	import ddpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  go,
	input  logic signed [MA_W-1:0] a,
	input  logic signed [MB_W-1:0] b,
	output logic signed [P_W-1:0]  prod
);

	logic signed [P_W-1:0] prod_q;

	// product holds until the next launch
	always_ff @(posedge clk) begin
		if (go)
			prod_q <= P_W'(a) * P_W'(b);
	end

	assign prod = prod_q;

endmodule

// ----- rtl/ddpc_wrap.sv -----
module ddpc_wrap
	import ddpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [WR_W-1:0] a,
	output logic                   done,
	output logic signed [HD_W-1:0] res
);

	logic        busy_q;
	logic        fin_q;
	logic        done_q;
	logic        neg_q;
	logic [31:0] r_q;
	logic [3:0]  k_q;
	logic signed [HD_W-1:0] res_q;

	logic [32:0]        t;
	logic [HD_W-1:0]    rr;
	logic signed [19:0] rs;

	// restoring reduction of |a| by 2*pi, one shifted modulus per cycle
	always_comb begin
		t  = 33'(Q_TWO_PI) << k_q;
		rr = (neg_q && r_q != 32'd0) ? HD_W'(Q_TWO_PI) - r_q[HD_W-1:0] : r_q[HD_W-1:0];
		rs = $signed({1'b0, rr});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q && k_q == 4'd0;
			if (start)
				busy_q <= 1'b1;
			else if (k_q == 4'd0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[WR_W-1];
			r_q   <= a[WR_W-1] ? 32'(-a) : 32'(a);
			k_q   <= 4'(WRAP_TOP);
		end else if (busy_q) begin
			if ({1'b0, r_q} >= t)
				r_q <= r_q - t[31:0];
			if (k_q != 4'd0)
				k_q <= k_q - 4'd1;
		end
		if (fin_q)
			res_q <= (rs > Q_PI) ? HD_W'(rs - 20'(Q_TWO_PI)) : HD_W'(rs);
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- rtl/ddpc_cordic.sv -----
module ddpc_cordic
	import ddpc_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cordic_ctl_t            ctl,
	input  logic signed [XY_W-1:0] x0,
	input  logic signed [XY_W-1:0] y0,
	input  logic signed [Z_W-1:0]  z0,
	output logic                   done,
	output logic signed [XY_W-1:0] x,
	output logic signed [XY_W-1:0] y,
	output logic signed [Z_W-1:0]  z
);

	localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

	logic busy_q;
	logic done_q;
	logic rot_q;
	logic [4:0] i_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;

	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  at;
	logic                   cw;

	// rotation steers z to zero, vectoring steers y to zero; same update pair
	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = $signed({{(Z_W - 17){1'b0}}, atan_lut(i_q)});
		cw = rot_q ? !z_q[Z_W-1] : !(y_q > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && i_q == LAST && !ctl.start;
			if (ctl.start)
				busy_q <= 1'b1;
			else if (i_q == LAST)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			i_q   <= 5'd0;
			rot_q <= ctl.rotate;
		end else if (busy_q) begin
			if (cw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
			if (i_q != LAST)
				i_q <= i_q + 5'd1;
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule
